[hdl/kbmi_pkg.sv]
// Shared types, constants and lookup functions for the keyframe bone matrix interpolator.
package kbmi_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int NCOMP     = 10;
  localparam int WORD_W    = DW * (NCOMP + 1);
  localparam int CNT_W     = 7;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int QP_W      = 64 - FRAC_BITS;
  localparam int FRAC_W    = FRAC_BITS + 1;

  // Fixed-point one.
  localparam logic signed [DW-1:0] ONE = DW'(1 << FRAC_BITS);

  // Component slots of one keyframe word; the key time sits above them.
  localparam logic [3:0] C_SX = 4'd0;
  localparam logic [3:0] C_SY = 4'd1;
  localparam logic [3:0] C_SZ = 4'd2;
  localparam logic [3:0] C_MX = 4'd3;
  localparam logic [3:0] C_MY = 4'd4;
  localparam logic [3:0] C_MZ = 4'd5;
  localparam logic [3:0] C_RX = 4'd6;
  localparam logic [3:0] C_RY = 4'd7;
  localparam logic [3:0] C_RZ = 4'd8;
  localparam logic [3:0] C_RW = 4'd9;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } kbmi_op_t;

  typedef struct packed {
    kbmi_op_t           opcode;
    logic signed [31:0] time_value;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_w;
  } kbmi_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
  } kbmi_out_t;

  // Write request into the keyframe store.
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } kbmi_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_CK0,
    S_RDL,
    S_CKL,
    S_SCAN_RD,
    S_SCAN_CK,
    S_DIV,
    S_RDA,
    S_RDB,
    S_RDW,
    S_LERP,
    S_QMUL,
    S_MMUL,
    S_EMIT
  } kbmi_state_t;

  // Quaternion product k uses components q_src_a(k) and q_src_b(k).
  // Order: xx, yy, zz, xy, xz, yz, xw, yw, zw.
  function automatic logic [3:0] q_src_a(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0, 4'd3, 4'd4, 4'd6: r = C_RX;
      4'd1, 4'd5, 4'd7:       r = C_RY;
      default:                r = C_RZ;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] q_src_b(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:                   r = C_RX;
      4'd1, 4'd3:             r = C_RY;
      4'd2, 4'd4, 4'd5:       r = C_RZ;
      default:                r = C_RW;
    endcase
    return r;
  endfunction

  // Matrix element k belongs to row k/3, scaled by that row's scale.
  function automatic logic [3:0] m_row(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = C_SX;
      4'd3, 4'd4, 4'd5: r = C_SY;
      default:          r = C_SZ;
    endcase
    return r;
  endfunction

  // Saturate a signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/kbmi_store.sv]
// Keyframe store: one word per key, one write port and one registered read port.
module kbmi_store
  import kbmi_pkg::*;
(
  input  logic              clk,
  input  kbmi_wr_t          wr,
  input  logic [KEY_AW-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [MAX_KEYS];

  // Write on request, read every cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/kbmi_mul.sv]
// Shared signed multiplier with a registered product.
module kbmi_mul
  import kbmi_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[hdl/keyframe_bone_matrix_interpolator.sv]
// Top level: keyframe table, segment search, divider and matrix sequencer.
//
// Usage: items arrive on in_valid/in_ready with in_data. A load item writes
// the next keyframe at the write pointer, which wraps at the key count, and
// gives no result; the block stays idle. An evaluate item gives a time;
// the block finds the bracketing keys, interpolates scale, translation and
// the raw quaternion, and returns the S*R*T matrix as four row items on
// out_valid/out_ready, row 3 marked by last_row.
// The time of an evaluate is set by the key scan (a read and a check per key
// through the single store read port), a 17-step restoring divider, and 28
// products on one shared 33x33 multiplier. The block is ready again after
// the last row is taken.
// in_ready is high only while the block is idle, so one item is in work at
// a time. A row waits in the output register while out_ready is low and the
// sequencer holds until all four rows are taken.
// cfg_we writes the key count (cfg_wdata) at once; write it only when idle.
// Reset (rst_n low, synchronous) sets the count to 1 and the write pointer
// to 0; the key store is not cleared, and keys must be loaded before use.
module keyframe_bone_matrix_interpolator
  import kbmi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kbmi_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kbmi_out_t  out_data,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  kbmi_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cfg_count_r;
  logic [CNT_W-1:0]  n_eff;
  logic [KEY_AW-1:0] wp_r;
  logic [KEY_AW-1:0] wp_eff;
  logic [CNT_W-1:0]  wp_inc;

  logic in_acc, ld_acc, ev_acc, out_acc;

  kbmi_wr_t          wr;
  logic [KEY_AW-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic signed [31:0] rd_time;

  logic signed [31:0]     t_r, prev_r;
  logic [CNT_W-1:0]       idx_r;
  logic [KEY_AW-1:0]      a_r, b_r;
  logic [FRAC_W-1:0]      f_r;
  logic [MUL_W:0]         rem_r;
  logic [MUL_W-1:0]       den_r;
  logic [4:0]             dcnt_r;
  logic [3:0]             cnt_r;
  logic [WORD_W-DW-1:0]   da_r, db_r;
  logic signed [31:0]     da_c [NCOMP];
  logic signed [31:0]     db_c [NCOMP];
  logic signed [31:0]     v_r  [NCOMP];
  logic signed [QP_W-1:0] qp_r [9];
  logic signed [31:0]     m_r  [9];
  logic signed [50:0]     qe   [9];
  logic signed [50:0]     r_raw [9];
  logic signed [31:0]     r_elem [9];

  logic                     hit;
  logic signed [MUL_W-1:0]  num_w, den_w;
  logic                     ge;
  logic [MUL_W:0]           rem_sub;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [3:0]               kprev;

  logic [1:0]  row_r;
  logic [1:0]  rsel;
  logic        out_valid_r;
  kbmi_out_t   out_r, row_build;

  // Effective key count and load pointer.
  always_comb begin
    if (cfg_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_count_r > CNT_W'(MAX_KEYS)) begin
      n_eff = CNT_W'(MAX_KEYS);
    end else begin
      n_eff = cfg_count_r;
    end
  end

  assign wp_eff  = ({1'b0, wp_r} >= n_eff) ? '0 : wp_r;
  assign wp_inc  = {1'b0, wp_eff} + CNT_W'(1);
  assign in_acc  = in_valid & in_ready;
  assign ld_acc  = in_acc & (in_data.opcode == OP_LOAD);
  assign ev_acc  = in_acc & (in_data.opcode == OP_EVAL);
  assign out_acc = out_valid_r & out_ready;

  // Keyframe word: components at 32-bit slots, time on top.
  assign wr.en   = ld_acc;
  assign wr.addr = wp_eff;
  assign wr.data = {in_data.time_value, in_data.rot_w, in_data.rot_z, in_data.rot_y,
                    in_data.rot_x, in_data.move_z, in_data.move_y, in_data.move_x,
                    in_data.scale_z, in_data.scale_y, in_data.scale_x};

  kbmi_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time = rdata[WORD_W-1 -: DW];

  // Component views of the two bracketing keys.
  for (genvar g = 0; g < NCOMP; g++) begin : g_comp
    assign da_c[g] = da_r[g*DW +: DW];
    assign db_c[g] = db_r[g*DW +: DW];
  end

  // Segment test and divider step.
  assign hit     = (t_r >= prev_r) && (t_r <= rd_time);
  assign num_w   = MUL_W'(t_r) - MUL_W'(prev_r);
  assign den_w   = MUL_W'(rd_time) - MUL_W'(prev_r);
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // Rotation matrix terms from the registered quaternion products.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      qe[k] = 51'(qp_r[k]);
    end
    r_raw[0] = 51'(ONE) - ((qe[1] + qe[2]) <<< 1);
    r_raw[1] = (qe[3] + qe[8]) <<< 1;
    r_raw[2] = (qe[4] - qe[7]) <<< 1;
    r_raw[3] = (qe[3] - qe[8]) <<< 1;
    r_raw[4] = 51'(ONE) - ((qe[0] + qe[2]) <<< 1);
    r_raw[5] = (qe[5] + qe[6]) <<< 1;
    r_raw[6] = (qe[4] + qe[7]) <<< 1;
    r_raw[7] = (qe[5] - qe[6]) <<< 1;
    r_raw[8] = 51'(ONE) - ((qe[0] + qe[1]) <<< 1);
    for (int k = 0; k < 9; k++) begin
      r_elem[k] = sat32(64'(r_raw[k]));
    end
  end

  kbmi_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign kprev = cnt_r - 4'd1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (ev_acc) state_nxt = S_RD0;
      S_RD0:     state_nxt = S_CK0;
      S_CK0:     state_nxt = (t_r <= rd_time) ? S_RDA : S_RDL;
      S_RDL:     state_nxt = S_CKL;
      S_CKL:     state_nxt = (t_r < rd_time) ? S_SCAN_RD : S_RDA;
      S_SCAN_RD: state_nxt = S_SCAN_CK;
      S_SCAN_CK: begin
        if (hit) begin
          state_nxt = (den_w != '0) ? S_DIV : S_RDA;
        end else if (idx_r + CNT_W'(1) >= n_eff) begin
          state_nxt = S_RDA;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DIV:     if (dcnt_r == 5'(FRAC_W - 1)) state_nxt = S_RDA;
      S_RDA:     state_nxt = S_RDB;
      S_RDB:     state_nxt = S_RDW;
      S_RDW:     state_nxt = S_LERP;
      S_LERP:    if (cnt_r == 4'(NCOMP)) state_nxt = S_QMUL;
      S_QMUL:    if (cnt_r == 4'd9) state_nxt = S_MMUL;
      S_MMUL:    if (cnt_r == 4'd9) state_nxt = S_EMIT;
      S_EMIT:    if (out_acc && (row_r == 2'd3)) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // State outputs: handshake, store address and multiplier operands.
  always_comb begin
    in_ready = 1'b0;
    raddr    = '0;
    op_a     = '0;
    op_b     = '0;
    unique case (state_r)
      S_IDLE:    in_ready = 1'b1;
      S_RDL:     raddr = KEY_AW'(n_eff - CNT_W'(1));
      S_SCAN_RD: raddr = idx_r[KEY_AW-1:0];
      S_RDA:     raddr = a_r;
      S_RDB:     raddr = b_r;
      S_LERP: begin
        if (cnt_r < 4'(NCOMP)) begin
          op_a = MUL_W'(db_c[cnt_r]) - MUL_W'(da_c[cnt_r]);
          op_b = MUL_W'(f_r);
        end
      end
      S_QMUL: begin
        if (cnt_r < 4'd9) begin
          op_a = MUL_W'(v_r[q_src_a(cnt_r)]);
          op_b = MUL_W'(v_r[q_src_b(cnt_r)]);
        end
      end
      S_MMUL: begin
        if (cnt_r < 4'd9) begin
          op_a = MUL_W'(v_r[m_row(cnt_r)]);
          op_b = MUL_W'(r_elem[cnt_r]);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_count_r <= CNT_W'(1);
      wp_r        <= '0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
      if (ld_acc) begin
        wp_r <= (wp_inc >= n_eff) ? '0 : wp_inc[KEY_AW-1:0];
      end
      if (state_r == S_MMUL && cnt_r == 4'd9) begin
        out_valid_r <= 1'b1;
        row_r       <= '0;
      end else if (out_acc) begin
        row_r <= row_r + 2'd1;
        if (row_r == 2'd3) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // Search, divider and arithmetic datapath.
  always_ff @(posedge clk) begin
    if (ev_acc) begin
      t_r <= in_data.time_value;
    end
    unique case (state_r)
      S_CK0: begin
        prev_r <= rd_time;
        a_r    <= '0;
        b_r    <= '0;
        f_r    <= '0;
      end
      S_CKL: begin
        a_r   <= KEY_AW'(n_eff - CNT_W'(1));
        b_r   <= KEY_AW'(n_eff - CNT_W'(1));
        f_r   <= '0;
        idx_r <= CNT_W'(1);
      end
      S_SCAN_CK: begin
        if (hit) begin
          a_r    <= KEY_AW'(idx_r - CNT_W'(1));
          b_r    <= idx_r[KEY_AW-1:0];
          f_r    <= '0;
          rem_r  <= {1'b0, num_w};
          den_r  <= den_w;
          dcnt_r <= '0;
        end else begin
          prev_r <= rd_time;
          idx_r  <= idx_r + CNT_W'(1);
        end
      end
      S_DIV: begin
        f_r    <= {f_r[FRAC_W-2:0], ge};
        rem_r  <= rem_sub << 1;
        dcnt_r <= dcnt_r + 5'd1;
      end
      S_RDB: da_r <= rdata[WORD_W-DW-1:0];
      S_RDW: begin
        db_r  <= rdata[WORD_W-DW-1:0];
        cnt_r <= '0;
      end
      S_LERP: begin
        if (cnt_r != '0) begin
          v_r[kprev] <= da_c[kprev] + prod_r[FRAC_BITS+31:FRAC_BITS];
        end
        cnt_r <= (cnt_r == 4'(NCOMP)) ? '0 : cnt_r + 4'd1;
      end
      S_QMUL: begin
        if (cnt_r != '0) begin
          qp_r[kprev] <= prod_r[63:FRAC_BITS];
        end
        cnt_r <= (cnt_r == 4'd9) ? '0 : cnt_r + 4'd1;
      end
      S_MMUL: begin
        if (cnt_r != '0) begin
          m_r[kprev] <= sat32(64'($signed(prod_r[63:FRAC_BITS])));
        end
        cnt_r <= (cnt_r == 4'd9) ? '0 : cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  // Row assembly for the output register.
  assign rsel = (state_r == S_MMUL) ? 2'd0 : row_r + 2'd1;

  always_comb begin
    row_build.row_index = rsel;
    row_build.last_row  = (rsel == 2'd3);
    case (rsel)
      2'd0: begin
        row_build.col0 = m_r[0];
        row_build.col1 = m_r[1];
        row_build.col2 = m_r[2];
        row_build.col3 = '0;
      end
      2'd1: begin
        row_build.col0 = m_r[3];
        row_build.col1 = m_r[4];
        row_build.col2 = m_r[5];
        row_build.col3 = '0;
      end
      2'd2: begin
        row_build.col0 = m_r[6];
        row_build.col1 = m_r[7];
        row_build.col2 = m_r[8];
        row_build.col3 = '0;
      end
      default: begin
        row_build.col0 = v_r[C_MX];
        row_build.col1 = v_r[C_MY];
        row_build.col2 = v_r[C_MZ];
        row_build.col3 = ONE;
      end
    endcase
  end

  // Load a row when the matrix completes and after each taken row but the last.
  always_ff @(posedge clk) begin
    if ((state_r == S_MMUL && cnt_r == 4'd9) || (out_acc && row_r != 2'd3)) begin
      out_r <= row_build;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A row is shown only while the sequencer is emitting.
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("row valid outside emit");

  // Taking the last row frees the block for the next item.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && row_r == 2'd3) |=> in_ready)
    else $error("block not ready after last row");

  // The write pointer stays inside the table in use after a load.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    ld_acc |=> ({1'b0, wp_r} < $past(n_eff)))
    else $error("write pointer out of range");

endmodule
